FILE: design/isort_pkg.sv
// Shared types and constants for the insertion sorter.
package isort_pkg;

    localparam int VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Controller states.
    typedef enum logic {
        ST_FILL,
        ST_EMIT
    } state_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic shift_out;
    } cell_ctrl_t;

endpackage

FILE: design/isort_cell.sv
// One compare-and-shift cell of the sorting chain.
module isort_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  isort_pkg::cell_ctrl_t ctrl,
    input  isort_pkg::value_t   new_value,
    input  isort_pkg::value_t   left_value,
    input  logic                left_valid,
    input  logic                left_gt,
    input  isort_pkg::value_t   right_value,
    input  logic                right_valid,
    output isort_pkg::value_t   value,
    output logic                valid,
    output logic                gt
);
    import isort_pkg::*;

    value_t value_reg;
    value_t value_next;
    logic   valid_reg;
    logic   valid_next;
    logic   take;

    // Strictly greater entries move up, so equal values keep arrival order.
    assign gt   = valid_reg && (new_value < value_reg);
    assign take = gt || (!valid_reg && left_valid);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift_out)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else if (ctrl.insert && take)
        begin
            value_next = left_gt ? left_value : new_value;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

FILE: design/insertion_sorter_unit.sv
// Top level of the insertion sorter: a chain of sorting cells and its controller.
//
//   Channel  | Handshake              | Signals
//   ---------+------------------------+------------------------------------------
//   input    | start && !busy         | value, end_of_set
//   result   | result_strobe          | sorted_value, final_result, overflowed
//
// One item is inserted per cycle while busy is low: every cell compares in parallel and
// shifts in one step. An item ending the set is followed by one result per stored entry,
// one per cycle, shifted out of the head of the chain; busy stays high until the final
// result is out. Reset empties the chain and clears the drop flag; no clearing pass is needed.
// The receiver cannot stall, so results leave at a fixed rate.
module insertion_sorter_unit #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  isort_pkg::value_t  value,
    input  logic               end_of_set,
    output logic               result_strobe,
    output isort_pkg::value_t  sorted_value,
    output logic               final_result,
    output logic               overflowed
);
    import isort_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic       drop_reg;
    logic       drop_next;
    cell_ctrl_t ctrl;
    logic       accept;
    logic       full;
    logic       last_out;

    value_t cell_value [CAPACITY];
    logic   cell_valid [CAPACITY];
    logic   cell_gt    [CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            value_t lv;
            logic   lval;
            logic   lgt;
            value_t rv;
            logic   rval;

            if (gi == 0)
            begin : g_head
                assign lv   = value;
                assign lval = 1'b1;
                assign lgt  = 1'b0;
            end
            else
            begin : g_mid_left
                assign lv   = cell_value[gi-1];
                assign lval = cell_valid[gi-1];
                assign lgt  = cell_gt[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign rv   = cell_value[gi];
                assign rval = 1'b0;
            end
            else
            begin : g_mid_right
                assign rv   = cell_value[gi+1];
                assign rval = cell_valid[gi+1];
            end

            isort_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_value   (value),
                .left_value  (lv),
                .left_valid  (lval),
                .left_gt     (lgt),
                .right_value (rv),
                .right_valid (rval),
                .value       (cell_value[gi]),
                .valid       (cell_valid[gi]),
                .gt          (cell_gt[gi])
            );
        end
    endgenerate

    assign full     = cell_valid[CAPACITY-1];
    assign last_out = !cell_valid[1];
    assign accept   = start && !busy;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (accept && end_of_set)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (last_out)
                begin
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    // Outputs and cell commands.
    always_comb
    begin
        busy           = 1'b0;
        result_strobe  = 1'b0;
        ctrl.insert    = 1'b0;
        ctrl.shift_out = 1'b0;
        case (state_reg)
            ST_FILL:
            begin
                ctrl.insert = start && !full;
            end
            ST_EMIT:
            begin
                busy           = 1'b1;
                result_strobe  = 1'b1;
                ctrl.shift_out = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // The drop flag is set by an item that finds the chain full and clears once the set is out.
    always_comb
    begin
        drop_next = drop_reg;
        if (accept && full)
        begin
            drop_next = 1'b1;
        end
        else if (result_strobe && last_out)
        begin
            drop_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drop_reg  <= drop_next;
        end
    end

    assign sorted_value = cell_value[0];
    assign final_result = last_out;
    assign overflowed   = drop_reg;

    // A result always comes from an occupied head cell.
    a_strobe_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> cell_valid[0])
        else $error("result shown from an empty head cell");

    // An item ending the set is followed at once by the first result.
    a_end_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_set) |=> result_strobe)
        else $error("no result after the item ending the set");

    // Results of a set come in an unbroken run.
    a_emit_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !final_result) |=> result_strobe)
        else $error("gap in the run of results");

    // After the final result the chain is empty and the drop flag clear.
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && final_result) |=> (!busy && !cell_valid[0] && !overflowed))
        else $error("state not cleared after the final result");

endmodule
